// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the delay frame encoder RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define DFE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define DFE_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/dfe_pkg.sv =====
// Shared constants and types for the delay frame encoder.
// No dependencies; imported by every module of the block.
package dfe_pkg;

	// Field widths
	localparam int DELAY_W = 6;
	localparam int CHUNK_W = 32;
	localparam int LEN_W   = 6;

	// Packing and frame geometry
	localparam int WORD_W       = 16;
	localparam int ACC_W        = 21;
	localparam int CNT_W        = 5;
	localparam int FRAME_DELAYS = 32;
	localparam int IDX_W        = 5;

	// Chunk constants
	localparam logic [CHUNK_W-1:0] PREAMBLE      = 32'h00F0_0000;
	localparam logic [LEN_W-1:0]   PREAMBLE_LEN  = 6'd32;
	localparam logic [LEN_W-1:0]   WORD_CHUNK_LEN = 6'd17;

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// One classified delay as it travels through the queue
	typedef struct packed {
		logic [DELAY_W-1:0] delay;
		logic               first;
		logic               last;
	} dfe_entry_t;

endpackage

// ===== rtl/dfe_front.sv =====
// Front end: accepts delays and tags each with its place in the frame.
// Depends on dfe_pkg.
module dfe_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [dfe_pkg::DELAY_W-1:0] delay,
	input  logic                    q_full,
	output logic                    q_wr,
	output dfe_pkg::dfe_entry_t     q_wr_entry
);
	import dfe_pkg::*;

	logic [IDX_W-1:0] idx_q;

	// Transaction taken when the queue has room
	assign q_wr = push && !q_full;

	// Classify by position in the frame
	always_comb begin
		q_wr_entry.delay = delay;
		q_wr_entry.first = (idx_q == '0);
		q_wr_entry.last  = (idx_q == IDX_W'(FRAME_DELAYS - 1));
	end

	// Frame position, wraps after the last delay
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (q_wr) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

endmodule

// ===== rtl/dfe_queue.sv =====
// Short FIFO of classified delays between front and back end.
// Depends on dfe_pkg and assert_macros.svh.
module dfe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  dfe_pkg::dfe_entry_t wr_entry,
	input  logic                rd,
	output dfe_pkg::dfe_entry_t rd_entry,
	output logic                not_empty,
	output logic                full
);
	import dfe_pkg::*;
	`include "assert_macros.svh"

	dfe_entry_t         mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign rd_entry  = mem_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (rd) rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			if (wr && !rd) count_q <= count_q + Q_CNT_W'(1);
			else if (rd && !wr) count_q <= count_q - Q_CNT_W'(1);
		end
	end

	`DFE_NEVER(a_q_overflow, wr && full, "queue written while full")
	`DFE_NEVER(a_q_underflow, rd && !not_empty, "queue read while empty")
	`DFE_ASSERT(a_q_level, count_q <= Q_CNT_W'(Q_DEPTH), "queue level beyond depth")

endmodule

// ===== rtl/dfe_back.sv =====
// Back end: packs queued delays into 16-bit words and builds frame chunks.
// Depends on dfe_pkg and assert_macros.svh.
module dfe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dfe_pkg::dfe_entry_t         head,
	input  logic                        head_valid,
	output logic                        head_pop,
	output logic [dfe_pkg::CHUNK_W-1:0] chunk_bits,
	output logic [dfe_pkg::LEN_W-1:0]   chunk_length,
	output logic                        end_of_frame,
	output logic                        empty,
	input  logic                        pop
);
	import dfe_pkg::*;
	`include "assert_macros.svh"

	// Packing state
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] chk_q;
	logic              chk_pending_q;

	// Output register
	logic               out_valid_q;
	logic [CHUNK_W-1:0] out_bits_q;
	logic [LEN_W-1:0]   out_len_q;
	logic               out_eof_q;

	logic [ACC_W-1:0]  acc_shift;
	logic [CNT_W-1:0]  cnt_add;
	logic [CNT_W-1:0]  rest;
	logic [ACC_W-1:0]  rest_mask;
	logic [WORD_W-1:0] word;
	logic              word_done;
	logic              out_free;

	logic               out_load;
	logic [CHUNK_W-1:0] out_bits_d;
	logic [LEN_W-1:0]   out_len_d;
	logic               out_eof_d;
	logic               pack_upd;
	logic               frame_clr;
	logic               pend_set;

	assign empty        = !out_valid_q;
	assign chunk_bits   = out_bits_q;
	assign chunk_length = out_len_q;
	assign end_of_frame = out_eof_q;
	assign out_free     = !out_valid_q || pop;

	// Shift the new delay in and cut off a word once 16 bits are held
	always_comb begin
		acc_shift = {acc_q[ACC_W-DELAY_W-1:0], head.delay};
		cnt_add   = cnt_q + CNT_W'(DELAY_W);
		word_done = (cnt_add >= CNT_W'(WORD_W));
		rest      = cnt_add - CNT_W'(WORD_W);
		word      = WORD_W'(acc_shift >> rest);
		rest_mask = (ACC_W'(1) << rest) - ACC_W'(1);
	end

	// Decide what the head transaction does this cycle
	always_comb begin
		out_load   = 1'b0;
		out_bits_d = CHUNK_W'({word, 1'b1});
		out_len_d  = WORD_CHUNK_LEN;
		out_eof_d  = 1'b0;
		pack_upd   = 1'b0;
		frame_clr  = 1'b0;
		pend_set   = 1'b0;
		head_pop   = 1'b0;
		if (head_valid) begin
			if (chk_pending_q) begin
				// second chunk of the last delay: checksum closes the frame
				if (out_free) begin
					out_load   = 1'b1;
					out_bits_d = CHUNK_W'({chk_q, 1'b1});
					out_eof_d  = 1'b1;
					frame_clr  = 1'b1;
					head_pop   = 1'b1;
				end
			end else if (head.first) begin
				if (out_free) begin
					out_load   = 1'b1;
					out_bits_d = PREAMBLE;
					out_len_d  = PREAMBLE_LEN;
					pack_upd   = 1'b1;
					head_pop   = 1'b1;
				end
			end else if (head.last) begin
				if (out_free) begin
					out_load = word_done;
					pack_upd = 1'b1;
					pend_set = 1'b1;
				end
			end else if (word_done) begin
				if (out_free) begin
					out_load = 1'b1;
					pack_upd = 1'b1;
					head_pop = 1'b1;
				end
			end else begin
				// no chunk: absorb the delay at once
				pack_upd = 1'b1;
				head_pop = 1'b1;
			end
		end
	end

	// Packing state and checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			cnt_q         <= '0;
			chk_q         <= '0;
			chk_pending_q <= 1'b0;
		end else if (frame_clr) begin
			acc_q         <= '0;
			cnt_q         <= '0;
			chk_q         <= '0;
			chk_pending_q <= 1'b0;
		end else begin
			if (pend_set) chk_pending_q <= 1'b1;
			if (pack_upd) begin
				if (word_done) begin
					acc_q <= acc_shift & rest_mask;
					cnt_q <= rest;
					chk_q <= chk_q ^ word;
				end else begin
					acc_q <= acc_shift;
					cnt_q <= cnt_add;
				end
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_bits_q <= out_bits_d;
			out_len_q  <= out_len_d;
			out_eof_q  <= out_eof_d;
		end
	end

	`DFE_ASSERT(a_pend_on_last, chk_pending_q |-> (head_valid && head.last),
		"checksum pending without the last delay at the head")
	`DFE_ASSERT(a_eof_len, (out_valid_q && out_eof_q) |-> (out_len_q == WORD_CHUNK_LEN),
		"frame end on a chunk that is not 17 bits")
	`DFE_NEVER(a_load_over, out_load && !out_free, "result overwritten before taken")

endmodule

// ===== rtl/delay_frame_encoder.sv =====
// Delay frame encoder: packs 32 six-bit delays into a 253-bit serial frame.
// Result ports are registered; a taken delay is written into the queue, and any chunk
// it yields is loaded into the output register by the back end once that register is free.
// The queue can take new delays while the packer works; the last delay of a frame
// holds the packer for its word chunk and then for the checksum chunk.
// Reset (arst_n low) empties the queue and output and restarts the frame.
module delay_frame_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [dfe_pkg::DELAY_W-1:0] delay,
	output logic                        empty,
	input  logic                        pop,
	output logic [dfe_pkg::CHUNK_W-1:0] chunk_bits,
	output logic [dfe_pkg::LEN_W-1:0]   chunk_length,
	output logic                        end_of_frame
);
	import dfe_pkg::*;

	logic       q_wr;
	dfe_entry_t q_wr_entry;
	dfe_entry_t q_head;
	logic       q_not_empty;
	logic       q_rd;

	// Front: take and classify
	dfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.delay      (delay),
		.q_full     (full),
		.q_wr       (q_wr),
		.q_wr_entry (q_wr_entry)
	);

	// Queue between front and back
	dfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (q_wr),
		.wr_entry  (q_wr_entry),
		.rd        (q_rd),
		.rd_entry  (q_head),
		.not_empty (q_not_empty),
		.full      (full)
	);

	// Back: pack, checksum and emit chunks
	dfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.head_valid   (q_not_empty),
		.head_pop     (q_rd),
		.chunk_bits   (chunk_bits),
		.chunk_length (chunk_length),
		.end_of_frame (end_of_frame),
		.empty        (empty),
		.pop          (pop)
	);

endmodule
